// File: rtl/rbmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbmf_pkg
// shared register codes, field widths and the lane control bundle
// ----------------------------------------------------------------------------
package rbmf_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // register field widths
  localparam int RADIUS_BITS = 2;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;

  // width of one output sample
  localparam int OUT_BITS = 8;

  // control from the sequencer to every channel lane
  typedef struct packed {
    logic clear;      // zero the accumulator
    logic add;        // add the sample read from the row store
    logic div_start;  // start dividing the sum by the window area
  } lane_ctrl_t;

endpackage

// File: rtl/rbmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbmf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rbmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 11264
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rbmf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbmf_lane
// one color channel: window sum accumulator and a restoring divider
// ----------------------------------------------------------------------------
module rbmf_lane #(
  parameter int SAMPLE_BITS = 8,
  parameter int MAX_RADIUS  = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rbmf_pkg::lane_ctrl_t   ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] area_i,
  output logic [rbmf_pkg::OUT_BITS-1:0] mean_o,
  output logic                   done_o
);

  localparam int AREA_MAX = (2*MAX_RADIUS+1)*(2*MAX_RADIUS+1);
  localparam int AREA_W   = $clog2(AREA_MAX+1);
  localparam int SUM_W    = $clog2(AREA_MAX*((1 << SAMPLE_BITS) - 1) + 1);
  localparam int STEP_W   = $clog2(SUM_W+1);

  // accumulator doubles as the quotient shift register
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [AREA_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [AREA_W:0]   trial;

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    trial  = {rem_q, acc_q[SUM_W-1]};
    if (ctrl_i.clear) begin
      acc_d  = '0;
      done_d = 1'b0;
    end else if (ctrl_i.add) begin
      acc_d = acc_q + SUM_W'(sample_i);
    end else if (ctrl_i.div_start) begin
      rem_d  = '0;
      step_d = STEP_W'(SUM_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (trial >= {1'b0, area_i}) begin
        rem_d = AREA_W'(trial - {1'b0, area_i});
        acc_d = {acc_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[AREA_W-1:0];
        acc_d = {acc_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign mean_o = acc_q[rbmf_pkg::OUT_BITS-1:0];
  assign done_o = done_q;

endmodule

// File: rtl/rgb_box_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_mean_filter
// zero-padded square mean filter over an rgb pixel stream
// ----------------------------------------------------------------------------
// usage:
// - pixels enter on s_axis in raster order, tuser high marks a drain word
// - averaged pixels leave on m_axis in raster order, tlast on the last one
// - output k of a frame leaves on input word k + r*W + r; after the last
//   pixel, r*W + r drain words push out the remaining outputs
// - the apb port sets radius, width and height; a write restarts the frame
// - one word at a time: a word producing a result walks its (2r+1)^2
//   window through the row store (one read port), then the control
//   starts a serial divide of one bit per cycle and loads the output
//   register; a word with no result leaves the sequencer idle for the next word
// - a finished pixel waits in the output register, so the next input word
//   is accepted while the receiver stalls; a second result then waits
// - reset clears the counters and sets radius 1, width 640, height 480; the
//   row store is not cleared, only positions already received are ever read
// ----------------------------------------------------------------------------
module rgb_box_mean_filter #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RADIUS  = 3,
  parameter int SAMPLE_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: red_in, green_in, blue_in, zero fill
  input  logic [8*((3*SAMPLE_BITS+7)/8)-1:0] s_axis_tdata,
  // fields from bit 0: drain
  input  logic        s_axis_tuser,
  // pixel output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fields from bit 0: red_out, green_out, blue_out
  output logic [23:0] m_axis_tdata,
  // frame_end
  output logic        m_axis_tlast
);

  localparam int RING_ROWS = 3*MAX_RADIUS + 2;
  localparam int DEPTH     = RING_ROWS*MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SLOT_W    = $clog2(RING_ROWS);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = rbmf_pkg::HEIGHT_BITS;
  localparam int RAD_W     = $clog2(MAX_RADIUS+1);
  localparam int CNT_W     = $clog2(2*MAX_RADIUS+1);
  localparam int AREA_W    = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1);
  localparam int DLY_W     = $clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+2);
  localparam int PIX_W     = 3*SAMPLE_BITS;
  localparam int OB        = rbmf_pkg::OUT_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // configuration registers
  logic [rbmf_pkg::RADIUS_BITS-1:0] radius_q;
  logic [rbmf_pkg::WIDTH_BITS-1:0]  width_q;
  logic [rbmf_pkg::HEIGHT_BITS-1:0] height_q;
  logic                             cfg_we;

  // effective geometry
  logic [RAD_W-1:0]  r_eff;
  logic [COL_W:0]    w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [DLY_W-1:0]  delay;
  logic [RAD_W+1:0]  side;
  logic [AREA_W-1:0] area;

  // frame position state
  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [SLOT_W-1:0] in_slot_q, in_slot_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [DLY_W-1:0]  cnt_q, cnt_d, cnt_new;

  // window walk state
  logic signed [ROW_W+1:0] win_row_q, win_row_d;
  logic signed [COL_W+1:0] win_col_q, win_col_d;
  logic signed [COL_W+1:0] base_col_q, base_col_d;
  logic [SLOT_W-1:0]       win_slot_q, win_slot_d;
  logic [CNT_W-1:0]        dr_q, dr_d, dc_q, dc_d, r2;
  logic                    last_q, last_d;
  logic                    pend_q;
  logic                    in_range;
  logic [SLOT_W:0]         start_slot;

  // handshake and store access
  logic              in_acc;
  logic              pixel_ok;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PIX_W-1:0]  rdata;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [23:0]   out_data_q;
  logic          out_last_q;
  logic          out_load;

  rbmf_pkg::lane_ctrl_t lane_ctrl;
  logic [OB-1:0]        mean [3];
  logic [2:0]           lane_done;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rbmf_pkg::RADIUS_BITS'(1);
      width_q  <= rbmf_pkg::WIDTH_BITS'(640);
      height_q <= rbmf_pkg::HEIGHT_BITS'(480);
    end else if (cfg_we) begin
      case (paddr[3:2])
        rbmf_pkg::REG_RADIUS: radius_q <= pwdata[rbmf_pkg::RADIUS_BITS-1:0];
        rbmf_pkg::REG_WIDTH:  width_q  <= pwdata[rbmf_pkg::WIDTH_BITS-1:0];
        rbmf_pkg::REG_HEIGHT: height_q <= pwdata[rbmf_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rbmf_pkg::REG_RADIUS: prdata = 32'(radius_q);
      rbmf_pkg::REG_WIDTH:  prdata = 32'(width_q);
      rbmf_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:              prdata = '0;
    endcase
  end

  // saturate the registers to what the store supports, zero sizes count as one
  always_comb begin
    if (32'(radius_q) > MAX_RADIUS) r_eff = RAD_W'(MAX_RADIUS);
    else                            r_eff = RAD_W'(radius_q);
    if (width_q == '0)                 w_eff = (COL_W+1)'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = (COL_W+1)'(MAX_WIDTH);
    else                               w_eff = (COL_W+1)'(width_q);
    h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
    delay = DLY_W'(r_eff) * DLY_W'(w_eff) + DLY_W'(r_eff);
    side  = (RAD_W+2)'({r_eff, 1'b0}) + (RAD_W+2)'(1);
    area  = AREA_W'(side) * AREA_W'(side);
    r2    = CNT_W'({r_eff, 1'b0});
  end

  // ------------------------------------------------------------- sequencer
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pixel_ok      = in_row_q < h_eff;

  assign in_range = (win_row_q >= 0) && (win_row_q < $signed({2'b00, h_eff}))
                 && (win_col_q >= 0) && (win_col_q < $signed({1'b0, w_eff}));

  // ring slot of the top window row
  assign start_slot = ({1'b0, out_slot_q} >= (SLOT_W+1)'(r_eff))
                    ? {1'b0, out_slot_q} - (SLOT_W+1)'(r_eff)
                    : {1'b0, out_slot_q} + (SLOT_W+1)'(RING_ROWS) - (SLOT_W+1)'(r_eff);

  assign ram_we = in_acc && pixel_ok && !s_axis_tuser;
  assign waddr  = ADDR_W'(in_slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);
  assign ram_re = (state_q == S_SUM) && in_range;
  assign raddr  = ADDR_W'(win_slot_q) * ADDR_W'(MAX_WIDTH)
                + ADDR_W'(win_col_q[COL_W-1:0]);

  always_comb begin
    state_d    = state_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    cnt_d      = cnt_q;
    cnt_new    = (cnt_q > delay) ? cnt_q : cnt_q + DLY_W'(1);
    win_row_d  = win_row_q;
    win_col_d  = win_col_q;
    base_col_d = base_col_q;
    win_slot_d = win_slot_q;
    dr_d       = dr_q;
    dc_d       = dc_q;
    last_d     = last_q;
    lane_ctrl  = '0;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && !(pixel_ok && s_axis_tuser)) begin
          // advance the input position on an image pixel
          if (pixel_ok) begin
            if ((COL_W+1)'(in_col_q) + (COL_W+1)'(1) >= w_eff) begin
              in_col_d = '0;
              in_row_d = in_row_q + ROW_W'(1);
              in_slot_d = (in_slot_q == SLOT_W'(RING_ROWS-1)) ? '0
                                                              : in_slot_q + SLOT_W'(1);
            end else begin
              in_col_d = in_col_q + COL_W'(1);
            end
          end
          cnt_d = cnt_new;
          if (cnt_new > delay && out_row_q < h_eff) begin
            // a result is due: set up the window walk
            win_row_d  = $signed({2'b00, out_row_q}) - $signed((ROW_W+2)'(r_eff));
            win_col_d  = $signed({2'b00, out_col_q}) - $signed((COL_W+2)'(r_eff));
            base_col_d = $signed({2'b00, out_col_q}) - $signed((COL_W+2)'(r_eff));
            win_slot_d = start_slot[SLOT_W-1:0];
            dr_d       = '0;
            dc_d       = '0;
            last_d     = (out_row_q == h_eff - ROW_W'(1))
                      && ((COL_W+1)'(out_col_q) == w_eff - (COL_W+1)'(1));
            lane_ctrl.clear = 1'b1;
            state_d = S_SUM;
            if ((COL_W+1)'(out_col_q) + (COL_W+1)'(1) >= w_eff) begin
              out_col_d = '0;
              out_row_d = out_row_q + ROW_W'(1);
              out_slot_d = (out_slot_q == SLOT_W'(RING_ROWS-1)) ? '0
                                                                : out_slot_q + SLOT_W'(1);
            end else begin
              out_col_d = out_col_q + COL_W'(1);
            end
            if (last_d) begin
              // frame done: next word starts a new frame
              in_col_d   = '0;
              in_row_d   = '0;
              in_slot_d  = '0;
              out_col_d  = '0;
              out_row_d  = '0;
              out_slot_d = '0;
              cnt_d      = '0;
            end
          end
        end
      end
      S_SUM: begin
        lane_ctrl.add = pend_q;
        if (dc_q == r2) begin
          dc_d      = '0;
          win_col_d = base_col_q;
          dr_d      = dr_q + CNT_W'(1);
          win_row_d = win_row_q + (ROW_W+2)'(1);
          win_slot_d = (win_slot_q == SLOT_W'(RING_ROWS-1)) ? '0
                                                            : win_slot_q + SLOT_W'(1);
          if (dr_q == r2) begin
            state_d = S_WAIT;
          end
        end else begin
          dc_d      = dc_q + CNT_W'(1);
          win_col_d = win_col_q + (COL_W+2)'(1);
        end
      end
      S_WAIT: begin
        lane_ctrl.add = pend_q;
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        lane_ctrl.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (lane_done[0]) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a register write restarts the frame
    if (cfg_we) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      cnt_d      = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (out_load)                     out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      cnt_q       <= '0;
      dr_q        <= '0;
      dc_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      in_slot_q   <= in_slot_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_slot_q  <= out_slot_d;
      cnt_q       <= cnt_d;
      dr_q        <= dr_d;
      dc_q        <= dc_d;
      pend_q      <= ram_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_row_q  <= win_row_d;
    win_col_q  <= win_col_d;
    base_col_q <= base_col_d;
    win_slot_q <= win_slot_d;
    last_q     <= last_d;
    if (out_load) begin
      out_data_q <= {mean[2], mean[1], mean[0]};
      out_last_q <= last_q;
    end
  end

  // ------------------------------------------------------------ row store
  rbmf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata[PIX_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------- channel lanes
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rbmf_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_RADIUS  (MAX_RADIUS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (rdata[ch*SAMPLE_BITS +: SAMPLE_BITS]),
      .area_i   (area),
      .mean_o   (mean[ch]),
      .done_o   (lane_done[ch])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: tb/tb_rgb_box_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_box_mean_filter
// self-checking bench for the zero-padded rgb box mean filter
// ----------------------------------------------------------------------------
// a behavioral model of the window sums predicts every averaged pixel; a
// monitor compares each output word with the oldest prediction. directed
// tests cover sample extremes, radius and size limits, drain handling and
// frame restart, then random frames run under three flow-control mixes.
// ----------------------------------------------------------------------------
module tb_rgb_box_mean_filter;

  localparam int MAX_W     = 1024;
  localparam int MAX_R     = 3;
  localparam int RING_ROWS = 3 * MAX_R + 2;
  // cycles to let an unfinished pixel leave before touching registers
  localparam int SETTLE    = 120;

  typedef struct packed {
    logic [23:0] rgb;   // blue, green, red from msb down
    logic        last;
  } mean_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // fields from bit 0: red_in, green_in, blue_in
  logic [23:0] s_axis_tdata = '0;
  // fields from bit 0: drain
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // fields from bit 0: red_out, green_out, blue_out
  logic [23:0] m_axis_tdata;
  // frame_end
  logic        m_axis_tlast;

  rgb_box_mean_filter dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state: registers as written, positions, and the row ring
  logic [1:0]  radius_reg;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  int unsigned in_col, in_row, out_col, out_row, frame_items;
  logic [23:0] row_ring [RING_ROWS][MAX_W];

  mean_pixel_t expected_pixels[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int pixels_checked = 0;
  int frames_done = 0;
  int words_sent = 0;

  function automatic int unsigned eff_radius();
    return radius_reg > MAX_R ? MAX_R : radius_reg;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    return width_reg > MAX_W ? MAX_W : width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return height_reg == 0 ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; frame_items = 0;
  endfunction

  // feed one accepted word into the model, queue the pixel it releases
  function automatic void box_mean_predict(input logic drain, input logic [23:0] px);
    int unsigned r, w, h, area;
    int sum [3];
    int row, col;
    mean_pixel_t res;
    r = eff_radius(); w = eff_width(); h = eff_height();
    sum = '{0, 0, 0};
    if (in_row < h) begin
      if (drain) return;  // early drain word is dropped
      row_ring[in_row % RING_ROWS][in_col % MAX_W] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    frame_items++;
    if (frame_items <= r * w + r || out_row >= h) return;
    for (int dr = -int'(r); dr <= int'(r); dr++) begin
      row = int'(out_row) + dr;
      if (row < 0 || row >= int'(h)) continue;
      for (int dc = -int'(r); dc <= int'(r); dc++) begin
        col = int'(out_col) + dc;
        if (col < 0 || col >= int'(w)) continue;
        for (int ch = 0; ch < 3; ch++)
          sum[ch] += row_ring[row % RING_ROWS][col % MAX_W][8*ch +: 8];
      end
    end
    area = (2 * r + 1) * (2 * r + 1);
    for (int ch = 0; ch < 3; ch++) res.rgb[8*ch +: 8] = 8'(sum[ch] / area);
    res.last = (out_row == h - 1) && (out_col == w - 1);
    expected_pixels.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (res.last) begin
      restart_frame();
      frames_done++;
    end
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // output monitor
  always @(posedge clk_i) begin
    mean_pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word rgb=%h last=%b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (m_axis_tdata !== want.rgb || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output %0d: expected rgb=%h last=%b, got rgb=%h last=%b",
                     pixels_checked, want.rgb, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // apb write of one register; the frame restarts
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      rbmf_pkg::REG_RADIUS: radius_reg = val[1:0];
      rbmf_pkg::REG_WIDTH:  width_reg  = val[10:0];
      rbmf_pkg::REG_HEIGHT: height_reg = val[12:0];
      default: ;
    endcase
    restart_frame();
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one input word; returns right after the accepting edge
  task automatic send_word(input logic drain, input logic [23:0] px);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= drain;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    box_mean_predict(drain, px);
    words_sent++;
  endtask

  // stop sending until every predicted pixel is out
  task automatic wait_drained(input bit settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    if (settle) repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [1:0] r, input logic [10:0] w, input logic [12:0] h);
    reg_write(rbmf_pkg::REG_RADIUS, 32'(r));
    reg_write(rbmf_pkg::REG_WIDTH, 32'(w));
    reg_write(rbmf_pkg::REG_HEIGHT, 32'(h));
  endtask

  // one whole frame: pixels from mode, then enough flush words
  // mode 0 random, 1 all zero, 2 all full scale
  task automatic send_frame(input int mode, input bit noisy);
    int unsigned n, flush;
    logic [23:0] px;
    n = eff_width() * eff_height();
    flush = eff_radius() * eff_width() + eff_radius();
    for (int unsigned i = 0; i < n; i++) begin
      px = mode == 1 ? 24'h0 : mode == 2 ? 24'hffffff : 24'($urandom);
      // ignored drain words mixed into the frame body
      if (noisy && $urandom_range(0, 19) == 0) send_word(1'b1, 24'($urandom));
      send_word(1'b0, px);
    end
    // stray pixels and drain words after the frame act as flush words
    for (int unsigned i = 0; i < flush; i++)
      send_word($urandom_range(0, 3) != 0, 24'($urandom));
  endtask

  task automatic test_defaults();
    // radius keeps its reset value of one
    reg_write(rbmf_pkg::REG_WIDTH, 32'd4);
    reg_write(rbmf_pkg::REG_HEIGHT, 32'd3);
    send_frame(0, 1'b0);
    wait_drained(1'b1);
  endtask

  task automatic test_extremes();
    set_frame(2'd0, 11'd3, 13'd2);       // radius zero passes pixels through
    send_frame(2, 1'b0);
    wait_drained(1'b1);
    set_frame(2'd3, 11'd2, 13'd2);       // window wider than the image
    send_frame(2, 1'b0);
    wait_drained(1'b1);
    set_frame(2'd3, 11'd1, 13'd1);       // single pixel, largest radius
    send_frame(2, 1'b0);
    wait_drained(1'b1);
    set_frame(2'd2, 11'd0, 13'd0);       // zero sizes count as one
    send_frame(1, 1'b0);
    wait_drained(1'b1);
    set_frame(2'd0, 11'd1100, 13'd1);    // width saturates at the maximum
    send_frame(0, 1'b0);
    wait_drained(1'b1);
  endtask

  task automatic test_drain_rules();
    set_frame(2'd1, 11'd3, 13'd3);
    send_word(1'b1, 24'h123456);         // drain before any pixel is ignored
    send_frame(0, 1'b1);
    send_frame(0, 1'b0);                 // back-to-back frames
    wait_drained(1'b1);
  endtask

  task automatic test_restart();
    // partial frame, then a register write drops it
    set_frame(2'd1, 11'd5, 13'd4);
    for (int i = 0; i < 9; i++) send_word(1'b0, 24'($urandom));
    wait_drained(1'b1);
    reg_write(rbmf_pkg::REG_RADIUS, 32'd1);
    send_frame(0, 1'b0);
    wait_drained(1'b1);
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int budget);
    int start, n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        // partial frame with full-range register values
        set_frame(2'($urandom), 11'($urandom), 13'($urandom));
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) send_word($urandom_range(0, 9) == 0, 24'($urandom));
        wait_drained(1'b1);
      end else begin
        set_frame(2'($urandom), 11'($urandom_range(1, 12)), 13'($urandom_range(1, 6)));
        send_frame(0, 1'b1);
        if ($urandom_range(0, 3) == 0) wait_drained(1'b0);  // sender holds off
        if ($urandom_range(0, 1) == 0) send_frame(0, 1'b1);
        wait_drained(1'b1);
      end
    end
  endtask

  initial begin
    radius_reg = 2'd1; width_reg = 11'd640; height_reg = 13'd480;
    restart_frame();
    foreach (row_ring[i, j]) row_ring[i][j] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 29; rx_idle_pct = 70;
    test_defaults();
    test_extremes();
    test_drain_rules();
    test_restart();
    test_random(29, 70, 200);
    test_random(70, 29, 200);
    test_random(0, 0, 200);
    wait_drained(1'b1);
    $display("words sent %0d, pixels checked %0d, frames completed %0d",
             words_sent, pixels_checked, frames_done);
    $display("radius 0..3, sizes from 1 up to saturation, drains and restarts covered");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("rgb_box_mean_filter: match");
    end else begin
      $display("rgb_box_mean_filter: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("rgb_box_mean_filter: mismatch");
    $finish;
  end

endmodule
